// ===== rtl/stp_pkg.sv =====
// Shared constants, codes, entry record and helpers for the section timing profiler.
// Used by section_timing_profiler_unit; depends on nothing.
`default_nettype none

package stp_pkg;

    localparam int SLOTS = 16;
    localparam int TIME_BITS = 48;
    localparam int KEY_BITS = 32;
    localparam int ACC_BITS = 64;
    localparam int CALL_BITS = 32;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_OUT_BITS = 4;
    localparam int STATUS_BITS = 3;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_RESTARTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NEW_ENTRY = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_RECORDED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [TIME_BITS-1:0] start;
        logic [ACC_BITS-1:0]  acc;
        logic [CALL_BITS-1:0] calls;
        logic [TIME_BITS-1:0] max0;
        logic [TIME_BITS-1:0] max1;
        logic [TIME_BITS-1:0] min0;
        logic [TIME_BITS-1:0] min1;
    } stat_t;

    localparam int STAT_BITS = $bits(stat_t);

    function automatic stat_t stat_reset();
        stat_t s;
        s = '0;
        s.min0 = '1;
        s.min1 = '1;
        return s;
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; no package needed.
`default_nettype none

module stp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/section_timing_profiler_unit.sv =====
// Top level of the section timing profiler: key table, statistics memory and result register.
// Depends on stp_pkg and stp_ram.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    command, probe_key, timestamp
//   output    out_valid / out_ready  status, slot, elapsed, total_time, call_count,
//                                    largest_time, second_largest, smallest_time,
//                                    second_smallest
//
// Each word is taken in S_IDLE, with the key match and the statistics read in the accept cycle,
// then the read-modify-write of the statistics memory entry is done in S_UPDATE.
// The registered read port of the statistics memory is why the update has a state of its own.
// Reset clears the used bits and the per-entry valid bits; the memory needs no clearing pass.
// A full result register holds the update step, so the input stalls until the result is taken.
`default_nettype none

module section_timing_profiler_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        command,
    input  wire logic [stp_pkg::KEY_BITS-1:0]      probe_key,
    input  wire logic [stp_pkg::TIME_BITS-1:0]     timestamp,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [stp_pkg::STATUS_BITS-1:0]        status,
    output logic [stp_pkg::SLOT_OUT_BITS-1:0]      slot,
    output logic [stp_pkg::TIME_BITS-1:0]          elapsed,
    output logic [stp_pkg::ACC_BITS-1:0]           total_time,
    output logic [stp_pkg::CALL_BITS-1:0]          call_count,
    output logic [stp_pkg::TIME_BITS-1:0]          largest_time,
    output logic [stp_pkg::TIME_BITS-1:0]          second_largest,
    output logic [stp_pkg::TIME_BITS-1:0]          smallest_time,
    output logic [stp_pkg::TIME_BITS-1:0]          second_smallest
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t                               state_reg;
    logic [stp_pkg::SLOTS-1:0]            entry_used_reg;
    logic [stp_pkg::SLOTS-1:0]            stat_valid_reg;
    logic [stp_pkg::KEY_BITS-1:0]         entry_key_reg [stp_pkg::SLOTS];

    logic [stp_pkg::STATUS_BITS-1:0]      op_reg;
    logic [stp_pkg::SLOT_W-1:0]           idx_reg;
    logic [stp_pkg::KEY_BITS-1:0]         key_reg;
    logic [stp_pkg::TIME_BITS-1:0]        ts_reg;

    logic                                 out_valid_reg;
    logic [stp_pkg::STATUS_BITS-1:0]      status_reg;
    logic [stp_pkg::SLOT_OUT_BITS-1:0]    slot_reg;
    logic [stp_pkg::TIME_BITS-1:0]        elapsed_reg;
    stp_pkg::stat_t                       result_reg;

    logic                                 accept;
    logic                                 finish;
    logic [stp_pkg::SLOTS-1:0]            hit_vec;
    logic [stp_pkg::SLOT_W-1:0]           look_idx;
    logic [stp_pkg::STATUS_BITS-1:0]      look_op;

    stp_pkg::stat_t                       ram_rd;
    stp_pkg::stat_t                       cur;
    stp_pkg::stat_t                       upd_next;
    logic [stp_pkg::TIME_BITS-1:0]        dur;
    logic                                 ram_we;
    logic                                 report_entry;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign finish = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < stp_pkg::SLOTS; i++)
        begin
            hit_vec[i] = entry_used_reg[i] && (entry_key_reg[i] == probe_key);
        end
    end

    always_comb
    begin
        look_idx = (|hit_vec) ? stp_pkg::first_set(hit_vec)
                              : stp_pkg::first_set(~entry_used_reg);
        case (command)
            stp_pkg::CMD_BEGIN:
            begin
                if (|hit_vec)
                begin
                    look_op = stp_pkg::ST_RESTARTED;
                end
                else if (!(&entry_used_reg))
                begin
                    look_op = stp_pkg::ST_NEW_ENTRY;
                end
                else
                begin
                    look_op = stp_pkg::ST_FULL;
                end
            end
            stp_pkg::CMD_END:
            begin
                look_op = (|hit_vec) ? stp_pkg::ST_RECORDED : stp_pkg::ST_UNKNOWN;
            end
            stp_pkg::CMD_CLEAR:
            begin
                look_op = stp_pkg::ST_CLEARED;
            end
            default:
            begin
                look_op = stp_pkg::ST_UNKNOWN;
            end
        endcase
    end

    stp_ram #(
        .WIDTH (stp_pkg::STAT_BITS),
        .DEPTH (stp_pkg::SLOTS)
    ) u_stat_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (upd_next),
        .rd_en   (accept),
        .rd_addr (look_idx),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        cur = stat_valid_reg[idx_reg] ? ram_rd : stp_pkg::stat_reset();
        dur = ts_reg - cur.start;
        upd_next = cur;
        ram_we = 1'b0;
        report_entry = 1'b0;
        case (op_reg)
            stp_pkg::ST_RESTARTED,
            stp_pkg::ST_NEW_ENTRY:
            begin
                upd_next.start = ts_reg;
                ram_we = finish;
                report_entry = 1'b1;
            end
            stp_pkg::ST_RECORDED:
            begin
                upd_next.acc = cur.acc + stp_pkg::ACC_BITS'(dur);
                if (!(&cur.calls))
                begin
                    upd_next.calls = cur.calls + 1'b1;
                end
                if (cur.max0 < dur)
                begin
                    upd_next.max1 = cur.max0;
                    upd_next.max0 = dur;
                end
                else if (cur.max1 < dur)
                begin
                    upd_next.max1 = dur;
                end
                if (cur.min0 > dur)
                begin
                    upd_next.min1 = cur.min0;
                    upd_next.min0 = dur;
                end
                else if (cur.min1 > dur)
                begin
                    upd_next.min1 = dur;
                end
                ram_we = finish;
                report_entry = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entry_used_reg <= '0;
            stat_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                        if (op_reg == stp_pkg::ST_CLEARED)
                        begin
                            stat_valid_reg <= '0;
                        end
                        else if (ram_we)
                        begin
                            stat_valid_reg[idx_reg] <= 1'b1;
                        end
                        if (op_reg == stp_pkg::ST_NEW_ENTRY)
                        begin
                            entry_used_reg[idx_reg] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= look_op;
            idx_reg <= look_idx;
            key_reg <= probe_key;
            ts_reg <= timestamp;
        end
        if (finish)
        begin
            status_reg <= op_reg;
            if (op_reg == stp_pkg::ST_NEW_ENTRY)
            begin
                entry_key_reg[idx_reg] <= key_reg;
            end
            if (report_entry)
            begin
                slot_reg <= stp_pkg::SLOT_OUT_BITS'(idx_reg);
                elapsed_reg <= (op_reg == stp_pkg::ST_RECORDED) ? dur : '0;
                result_reg <= upd_next;
            end
            else
            begin
                slot_reg <= '0;
                elapsed_reg <= '0;
                result_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign elapsed         = elapsed_reg;
    assign total_time      = result_reg.acc;
    assign call_count      = result_reg.calls;
    assign largest_time    = result_reg.max0;
    assign second_largest  = result_reg.max1;
    assign smallest_time   = result_reg.min0;
    assign second_smallest = result_reg.min1;

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_UPDATE))
        else $error("Accepted word did not enter the update step.");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_UPDATE) && !(out_valid_reg && !out_ready))
        else $error("Statistics write outside a completing update step.");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("More than one used entry matches the probe key.");

    a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(entry_used_reg) & ~entry_used_reg) == '0))
        else $error("A used entry was released.");

endmodule

`default_nettype wire

// ===== bench/section_timing_profiler_checker.sv =====
// Scoreboard for the section timing profiler: watches both channels, keeps its own copy of the
// probe table, predicts every result word and compares it field by field. Depends on stp_pkg.
`default_nettype none

module section_timing_profiler_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [1:0]                         command,
    input  wire logic [stp_pkg::KEY_BITS-1:0]       probe_key,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      timestamp,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [stp_pkg::STATUS_BITS-1:0]    status,
    input  wire logic [stp_pkg::SLOT_OUT_BITS-1:0]  slot,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      elapsed,
    input  wire logic [stp_pkg::ACC_BITS-1:0]       total_time,
    input  wire logic [stp_pkg::CALL_BITS-1:0]      call_count,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      largest_time,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      second_largest,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      smallest_time,
    input  wire logic [stp_pkg::TIME_BITS-1:0]      second_smallest,
    output int                                      mismatches,
    output int                                      results_pending
);

    typedef struct packed {
        logic [stp_pkg::STATUS_BITS-1:0]   status;
        logic [stp_pkg::SLOT_OUT_BITS-1:0] slot;
        logic [stp_pkg::TIME_BITS-1:0]     elapsed;
        logic [stp_pkg::ACC_BITS-1:0]      total;
        logic [stp_pkg::CALL_BITS-1:0]     calls;
        logic [stp_pkg::TIME_BITS-1:0]     max0;
        logic [stp_pkg::TIME_BITS-1:0]     max1;
        logic [stp_pkg::TIME_BITS-1:0]     min0;
        logic [stp_pkg::TIME_BITS-1:0]     min1;
    } probe_report_t;

    logic                          probe_used [stp_pkg::SLOTS];
    logic [stp_pkg::KEY_BITS-1:0]  probe_id [stp_pkg::SLOTS];
    stp_pkg::stat_t                probe_stats [stp_pkg::SLOTS];
    probe_report_t                 expected_reports [$];
    probe_report_t                 seen;
    probe_report_t                 wanted;

    function automatic stp_pkg::stat_t fresh_stats();
        stp_pkg::stat_t s;
        s = '0;
        s.min0 = '1;
        s.min1 = '1;
        return s;
    endfunction

    function automatic probe_report_t entry_report(logic [stp_pkg::STATUS_BITS-1:0] st,
                                                   int idx,
                                                   logic [stp_pkg::TIME_BITS-1:0] d);
        probe_report_t r;
        r = '0;
        r.status = st;
        r.slot = stp_pkg::SLOT_OUT_BITS'(idx);
        r.elapsed = d;
        r.total = probe_stats[idx].acc;
        r.calls = probe_stats[idx].calls;
        r.max0 = probe_stats[idx].max0;
        r.max1 = probe_stats[idx].max1;
        r.min0 = probe_stats[idx].min0;
        r.min1 = probe_stats[idx].min1;
        return r;
    endfunction

    function automatic probe_report_t predict_probe_event(logic [1:0] cmd,
                                                          logic [stp_pkg::KEY_BITS-1:0] key,
                                                          logic [stp_pkg::TIME_BITS-1:0] ts);
        probe_report_t r;
        int hit;
        int free_slot;
        logic [stp_pkg::TIME_BITS-1:0] d;
        r = '0;
        r.status = stp_pkg::ST_UNKNOWN;
        hit = -1;
        free_slot = -1;
        for (int i = stp_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (probe_used[i] && probe_id[i] == key)
            begin
                hit = i;
            end
            if (!probe_used[i])
            begin
                free_slot = i;
            end
        end
        case (cmd)
            stp_pkg::CMD_BEGIN:
            begin
                if (hit >= 0)
                begin
                    probe_stats[hit].start = ts;
                    r = entry_report(stp_pkg::ST_RESTARTED, hit, '0);
                end
                else if (free_slot >= 0)
                begin
                    probe_used[free_slot] = 1'b1;
                    probe_id[free_slot] = key;
                    probe_stats[free_slot].start = ts;
                    r = entry_report(stp_pkg::ST_NEW_ENTRY, free_slot, '0);
                end
                else
                begin
                    r.status = stp_pkg::ST_FULL;
                end
            end
            stp_pkg::CMD_END:
            begin
                if (hit >= 0)
                begin
                    d = ts - probe_stats[hit].start;
                    probe_stats[hit].acc = probe_stats[hit].acc + stp_pkg::ACC_BITS'(d);
                    if (probe_stats[hit].calls != '1)
                    begin
                        probe_stats[hit].calls = probe_stats[hit].calls + 1'b1;
                    end
                    if (probe_stats[hit].max0 < d)
                    begin
                        probe_stats[hit].max1 = probe_stats[hit].max0;
                        probe_stats[hit].max0 = d;
                    end
                    else if (probe_stats[hit].max1 < d)
                    begin
                        probe_stats[hit].max1 = d;
                    end
                    if (probe_stats[hit].min0 > d)
                    begin
                        probe_stats[hit].min1 = probe_stats[hit].min0;
                        probe_stats[hit].min0 = d;
                    end
                    else if (probe_stats[hit].min1 > d)
                    begin
                        probe_stats[hit].min1 = d;
                    end
                    r = entry_report(stp_pkg::ST_RECORDED, hit, d);
                end
            end
            stp_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < stp_pkg::SLOTS; i++)
                begin
                    if (probe_used[i])
                    begin
                        probe_stats[i] = fresh_stats();
                    end
                end
                r.status = stp_pkg::ST_CLEARED;
            end
            default:
            begin
                r.status = stp_pkg::ST_UNKNOWN;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < stp_pkg::SLOTS; i++)
            begin
                probe_used[i] = 1'b0;
                probe_id[i] = '0;
                probe_stats[i] = fresh_stats();
            end
            expected_reports.delete();
            mismatches = 0;
            results_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {status, slot, elapsed, total_time, call_count, largest_time,
                        second_largest, smallest_time, second_smallest};
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("result word arrived with no prediction waiting");
                end
                else
                begin
                    wanted = expected_reports.pop_front();
                    check_field("status", 64'(seen.status), 64'(wanted.status));
                    check_field("slot", 64'(seen.slot), 64'(wanted.slot));
                    check_field("elapsed", 64'(seen.elapsed), 64'(wanted.elapsed));
                    check_field("total_time", seen.total, wanted.total);
                    check_field("call_count", 64'(seen.calls), 64'(wanted.calls));
                    check_field("largest_time", 64'(seen.max0), 64'(wanted.max0));
                    check_field("second_largest", 64'(seen.max1), 64'(wanted.max1));
                    check_field("smallest_time", 64'(seen.min0), 64'(wanted.min0));
                    check_field("second_smallest", 64'(seen.min1), 64'(wanted.min1));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(predict_probe_event(command, probe_key, timestamp));
            end
            results_pending = expected_reports.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/section_timing_profiler_unit_test.sv =====
// Top of the section timing profiler bench: clock, reset, begin/end/clear stimulus and the
// result-side ready pattern. Depends on stp_pkg, section_timing_profiler_unit and the checker.
`default_nettype none

module section_timing_profiler_unit_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WORD_TARGET = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [1:0]                         command;
    logic [stp_pkg::KEY_BITS-1:0]       probe_key;
    logic [stp_pkg::TIME_BITS-1:0]      timestamp;
    logic                               out_valid;
    logic                               out_ready;
    logic [stp_pkg::STATUS_BITS-1:0]    status;
    logic [stp_pkg::SLOT_OUT_BITS-1:0]  slot;
    logic [stp_pkg::TIME_BITS-1:0]      elapsed;
    logic [stp_pkg::ACC_BITS-1:0]       total_time;
    logic [stp_pkg::CALL_BITS-1:0]      call_count;
    logic [stp_pkg::TIME_BITS-1:0]      largest_time;
    logic [stp_pkg::TIME_BITS-1:0]      second_largest;
    logic [stp_pkg::TIME_BITS-1:0]      smallest_time;
    logic [stp_pkg::TIME_BITS-1:0]      second_smallest;
    int                                 mismatches;
    int                                 results_pending;

    int                                 words_sent;
    int                                 cycle_count;
    bit                                 quiet;
    bit                                 hold_request;
    logic [stp_pkg::KEY_BITS-1:0]       known_keys [stp_pkg::SLOTS];

    section_timing_profiler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .probe_key(probe_key),
        .timestamp(timestamp),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .slot(slot),
        .elapsed(elapsed),
        .total_time(total_time),
        .call_count(call_count),
        .largest_time(largest_time),
        .second_largest(second_largest),
        .smallest_time(smallest_time),
        .second_smallest(second_smallest)
    );

    section_timing_profiler_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .probe_key(probe_key),
        .timestamp(timestamp),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .slot(slot),
        .elapsed(elapsed),
        .total_time(total_time),
        .call_count(call_count),
        .largest_time(largest_time),
        .second_largest(second_largest),
        .smallest_time(smallest_time),
        .second_smallest(second_smallest),
        .mismatches(mismatches),
        .results_pending(results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [stp_pkg::TIME_BITS-1:0] random_stamp();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[stp_pkg::TIME_BITS-1:0];
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [stp_pkg::KEY_BITS-1:0] key,
                             input logic [stp_pkg::TIME_BITS-1:0] ts);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        probe_key <= key;
        timestamp <= ts;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: a fresh stall per word, or one long hold-off when the stimulus asks for it.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (hold_request)
            begin
                stall = 250;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int pick;
        int kind;
        logic [stp_pkg::TIME_BITS-1:0] t;
        logic [stp_pkg::TIME_BITS-1:0] d;
        bit held_once;
        bit held_twice;
        bit drained_once;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = stp_pkg::CMD_BEGIN;
        probe_key = '0;
        timestamp = '0;
        words_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        held_once = 1'b0;
        held_twice = 1'b0;
        drained_once = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // End on an empty table, then timer wrap, equal durations, the unused command and a
        // clear, then fill every slot and overflow the table.
        send_word(stp_pkg::CMD_END, '0, '0);
        send_word(stp_pkg::CMD_BEGIN, '0, '0);
        send_word(stp_pkg::CMD_END, '0, '1);
        send_word(stp_pkg::CMD_BEGIN, '1, '1);
        send_word(stp_pkg::CMD_END, '1, '0);
        send_word(stp_pkg::CMD_BEGIN, '0, stp_pkg::TIME_BITS'(5));
        send_word(stp_pkg::CMD_END, '0, stp_pkg::TIME_BITS'(5));
        send_word(stp_pkg::CMD_END, '0, stp_pkg::TIME_BITS'(5));
        send_word(CMD_UNUSED, '0, '0);
        send_word(stp_pkg::CMD_CLEAR, '1, '1);
        send_word(stp_pkg::CMD_END, '0, stp_pkg::TIME_BITS'(10));
        known_keys[0] = '0;
        known_keys[1] = '1;
        for (int i = 2; i < stp_pkg::SLOTS; i++)
        begin
            known_keys[i] = stp_pkg::KEY_BITS'(100 + i);
            send_word(stp_pkg::CMD_BEGIN, known_keys[i], random_stamp());
        end
        send_word(stp_pkg::CMD_BEGIN, stp_pkg::KEY_BITS'(200), '0);

        while (words_sent < WORD_TARGET)
        begin
            quiet = ((words_sent / 150) % 4) == 3;
            if (!held_once && words_sent >= 400)
            begin
                held_once = 1'b1;
                hold_request = 1'b1;
            end
            if (!held_twice && words_sent >= 950)
            begin
                held_twice = 1'b1;
                hold_request = 1'b1;
            end
            if (!drained_once && words_sent >= 650)
            begin
                drained_once = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, stp_pkg::SLOTS - 1);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                t = random_stamp();
                case ($urandom_range(0, 3))
                    0: d = stp_pkg::TIME_BITS'($urandom_range(0, 3));
                    1: d = stp_pkg::TIME_BITS'($urandom_range(0, 5000));
                    2: d = stp_pkg::TIME_BITS'($urandom());
                    default: d = random_stamp();
                endcase
                send_word(stp_pkg::CMD_BEGIN, known_keys[pick], t);
                send_word(stp_pkg::CMD_END, known_keys[pick], t + d);
            end
            else if (kind < 80)
            begin
                send_word(stp_pkg::CMD_END, known_keys[pick], random_stamp());
            end
            else if (kind < 88)
            begin
                send_word(stp_pkg::CMD_BEGIN, known_keys[pick], random_stamp());
            end
            else if (kind < 94)
            begin
                send_word($urandom_range(0, 1) ? stp_pkg::CMD_BEGIN : stp_pkg::CMD_END,
                          stp_pkg::KEY_BITS'($urandom()), random_stamp());
            end
            else if (kind < 97)
            begin
                send_word(stp_pkg::CMD_CLEAR, stp_pkg::KEY_BITS'($urandom()), random_stamp());
            end
            else
            begin
                send_word(CMD_UNUSED, stp_pkg::KEY_BITS'($urandom()), random_stamp());
            end
        end

        drain_results();
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
